/* sv/assert_macros.svh */
// assertion macros for the rtl files of the shortest distance block
// depends on nothing; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold in the same cycle as the trigger
`define ASSERT_SAME(lbl, clk, rstn, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (prop)) \
        else $error("assertion failed in dgsd");

// property must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rstn, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
        else $error("assertion failed in dgsd");

`endif

/* sv/dgsd_pkg.sv */
// shared types and constants for the dense graph shortest distance block
// no dependencies; imported by controller, datapath and top level
package dgsd_pkg;

    localparam int MAX_NODES    = 16;
    localparam int WEIGHT_BITS  = 8;
    localparam int RESULT_LIMIT = 16;
    localparam int N_LIMIT      = (MAX_NODES < RESULT_LIMIT) ? MAX_NODES : RESULT_LIMIT;
    localparam int NODE_BITS    = $clog2(MAX_NODES);
    localparam int CNT_BITS     = NODE_BITS + 1;
    localparam int CFG_BITS     = 5;
    localparam int MAT_DEPTH    = MAX_NODES * MAX_NODES;
    localparam int MAT_ABITS    = $clog2(MAT_DEPTH);
    localparam int DIST_BITS    = 12;

    // bit DIST_BITS set marks an unreached node
    localparam logic [DIST_BITS:0]   DIST_INF = {1'b1, {DIST_BITS{1'b0}}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_COMPUTE = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [3:0] row_node;
        logic [3:0] col_node;
        logic [7:0] edge_weight;
        logic [3:0] source_node;
    } in_item_t;

    typedef struct packed {
        logic [3:0]           node_index;
        logic [DIST_BITS-1:0] distance;
        logic                 reachable;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic                 weight_wr;
        logic                 init;
        logic                 seed;
        logic                 pick;
        logic                 relax_issue;
        logic                 emit_load;
        logic                 emit_last;
        logic [NODE_BITS-1:0] idx;
    } dgsd_cmd_t;

    typedef struct packed {
        logic cand_found;
    } dgsd_status_t;

endpackage

/* sv/dgsd_datapath.sv */
// datapath: weight matrix memory, distance and visited registers, relax and min tracking
// depends on dgsd_pkg; driven by dgsd_ctrl commands
module dgsd_datapath
    import dgsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  in_item_t     req_data,
    input  dgsd_cmd_t    cmd,
    output dgsd_status_t status,
    output out_item_t    rsp_data
);

    logic [WEIGHT_BITS-1:0] mem [MAT_DEPTH];
    logic [MAT_DEPTH-1:0]   wvalid_reg;
    logic [WEIGHT_BITS-1:0] rd_reg;
    logic                   rdv_reg;

    logic                   rel_v_reg;
    logic [NODE_BITS-1:0]   rel_k_reg;

    logic [DIST_BITS:0]     dist_reg [MAX_NODES];
    logic [MAX_NODES-1:0]   visited_reg;
    logic [NODE_BITS-1:0]   best_reg;
    logic [DIST_BITS-1:0]   best_d_reg;
    logic [DIST_BITS:0]     cand_d_reg;
    logic [NODE_BITS-1:0]   cand_idx_reg;
    out_item_t              out_reg;

    logic [MAT_ABITS-1:0]   wr_addr;
    logic [MAT_ABITS-1:0]   rd_addr;
    logic [NODE_BITS-1:0]   src_idx;
    logic [NODE_BITS-1:0]   rd_k;
    logic [DIST_BITS:0]     d_cur;
    logic                   vis_cur;
    logic [WEIGHT_BITS-1:0] w_cur;
    logic [DIST_BITS:0]     sum_raw;
    logic [DIST_BITS:0]     sum_sat;
    logic                   upd;
    logic [DIST_BITS:0]     new_d;
    logic                   better;

    assign wr_addr = MAT_ABITS'(req_data.row_node) * MAT_ABITS'(MAX_NODES)
                   + MAT_ABITS'(req_data.col_node);
    assign rd_addr = MAT_ABITS'(best_reg) * MAT_ABITS'(MAX_NODES) + MAT_ABITS'(cmd.idx);
    assign src_idx = NODE_BITS'(req_data.source_node);

    // matrix storage, never-written entries read as no edge
    always_ff @(posedge clk)
    begin
        if (cmd.weight_wr)
        begin
            mem[wr_addr] <= req_data.edge_weight[WEIGHT_BITS-1:0];
        end
        rd_reg  <= mem[rd_addr];
        rdv_reg <= wvalid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
        end
        else if (cmd.weight_wr)
        begin
            wvalid_reg[wr_addr] <= 1'b1;
        end
    end

    // one shared read port on the distance registers: relax or emit
    assign rd_k    = cmd.emit_load ? cmd.idx : rel_k_reg;
    assign d_cur   = dist_reg[rd_k];
    assign vis_cur = visited_reg[rel_k_reg];
    assign w_cur   = rdv_reg ? rd_reg : '0;
    assign sum_raw = {1'b0, best_d_reg} + (DIST_BITS+1)'(w_cur);
    assign sum_sat = sum_raw[DIST_BITS] ? {1'b0, DIST_MAX} : sum_raw;
    assign upd     = (w_cur != '0) && !vis_cur && (sum_sat < d_cur);
    assign new_d   = upd ? sum_sat : d_cur;
    assign better  = rel_v_reg && !vis_cur && (new_d < cand_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_v_reg   <= 1'b0;
            visited_reg <= '0;
            cand_d_reg  <= DIST_INF;
        end
        else
        begin
            rel_v_reg <= cmd.relax_issue;
            if (cmd.init)
            begin
                visited_reg <= '0;
                cand_d_reg  <= cmd.seed ? '0 : DIST_INF;
            end
            else if (cmd.pick)
            begin
                visited_reg[cand_idx_reg] <= 1'b1;
                cand_d_reg                <= DIST_INF;
            end
            else if (better)
            begin
                cand_d_reg <= new_d;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rel_k_reg <= cmd.idx;
        if (cmd.init)
        begin
            cand_idx_reg <= src_idx;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                dist_reg[i] <= (cmd.seed && (src_idx == NODE_BITS'(i))) ? '0 : DIST_INF;
            end
        end
        else
        begin
            if (cmd.pick)
            begin
                best_reg   <= cand_idx_reg;
                best_d_reg <= cand_d_reg[DIST_BITS-1:0];
            end
            else if (better)
            begin
                cand_idx_reg <= rel_k_reg;
            end
            if (rel_v_reg && upd)
            begin
                dist_reg[rel_k_reg] <= sum_sat;
            end
        end
        if (cmd.emit_load)
        begin
            out_reg.node_index <= 4'(cmd.idx);
            out_reg.distance   <= d_cur[DIST_BITS] ? '0 : d_cur[DIST_BITS-1:0];
            out_reg.reachable  <= !d_cur[DIST_BITS];
            out_reg.last       <= cmd.emit_last;
        end
    end

    assign status.cand_found = !cand_d_reg[DIST_BITS];
    assign rsp_data          = out_reg;

endmodule

/* sv/dgsd_ctrl.sv */
// controller: node count register, pass sequencing and result handshake
// depends on dgsd_pkg; commands dgsd_datapath
module dgsd_ctrl
    import dgsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  in_item_t            req_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  dgsd_status_t        status,
    output dgsd_cmd_t           cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PICK  = 5'b00010,
        S_RELAX = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_BITS-1:0]  node_count_reg;
    logic [NODE_BITS-1:0] k_reg, k_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [CNT_BITS-1:0]  n_eff;
    logic                 k_last;
    logic                 accept;
    logic                 slot_free;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CNT_BITS'(1);
        end
        else if (node_count_reg > CFG_BITS'(N_LIMIT))
        begin
            n_eff = CNT_BITS'(N_LIMIT);
        end
        else
        begin
            n_eff = CNT_BITS'(node_count_reg);
        end
    end

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign k_last    = (CNT_BITS'(k_reg) == (n_eff - CNT_BITS'(1)));
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        rsp_valid_next = rsp_ready ? 1'b0 : rsp_valid_reg;
        cmd            = '0;
        cmd.idx        = k_reg;
        cmd.seed       = CNT_BITS'(req_data.source_node) < n_eff;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_data.opcode == OP_COMPUTE)
                    begin
                        cmd.init   = 1'b1;
                        state_next = S_PICK;
                    end
                    else
                    begin
                        cmd.weight_wr = (CNT_BITS'(req_data.row_node) < n_eff)
                                     && (CNT_BITS'(req_data.col_node) < n_eff);
                    end
                end
            end
            S_PICK:
            begin
                k_next = '0;
                if (status.cand_found)
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_RELAX;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_RELAX:
            begin
                // matrix read issued here, relax happens in the next cycle
                cmd.relax_issue = 1'b1;
                if (k_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + NODE_BITS'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_PICK;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit_load  = 1'b1;
                    cmd.emit_last  = k_last;
                    rsp_valid_next = 1'b1;
                    if (k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + NODE_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            rsp_valid_reg  <= 1'b0;
            node_count_reg <= CFG_BITS'(16);
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

endmodule

/* sv/dense_graph_shortest_distances.sv */
// shortest distances over a dense weight matrix, array-based dijkstra
// write transactions are taken back to back while idle. a compute transaction with n nodes
// in use settles up to n nodes, each by a pick, a relax pass of one matrix read per cycle
// and a drain, then gives n results at one per cycle under no backpressure
// reset clears the whole matrix at once (per-entry valid flags) and sets node_count to 16
`include "assert_macros.svh"

module dense_graph_shortest_distances
    import dgsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  in_item_t            req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output out_item_t           rsp_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data
);

    dgsd_cmd_t    cmd;
    dgsd_status_t status;

    dgsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dgsd_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .status   (status),
        .rsp_data (rsp_data)
    );

    // a result waiting on the output is never overwritten
    `ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.emit_load, !rsp_valid || rsp_ready)
    // only one datapath operation per cycle
    `ASSERT_SAME(a_cmd_exclusive, clk, rst_n, 1'b1,
        $onehot0({cmd.weight_wr, cmd.init, cmd.pick, cmd.relax_issue, cmd.emit_load}))
    // a node is settled only when one was found
    `ASSERT_SAME(a_pick_found, clk, rst_n, cmd.pick, status.cand_found)
    // loading a result always presents it next cycle
    `ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit_load, rsp_valid)

endmodule

/* bench/dense_graph_shortest_distances_tb.sv */
// testbench for dense_graph_shortest_distances: drives edge writes and distance queries
// and checks every result against a matrix model kept in the bench
// depends on dgsd_pkg and the dense_graph_shortest_distances rtl
module dense_graph_shortest_distances_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dgsd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 320;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 1500;
    localparam int IDLE_PCT     = 23;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    in_item_t            req_data = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    out_item_t           rsp_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data = '0;

    in_item_t  pending_requests[$];
    out_item_t expected_distances[$];

    logic [WEIGHT_BITS-1:0] weight_model [MAT_DEPTH];
    logic [CFG_BITS-1:0]    node_count_model = CFG_BITS'(16);

    int accepted_items = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    dense_graph_shortest_distances DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int nodes_in_use(input logic [CFG_BITS-1:0] count);
        if (count == 0)
            return 1;
        if (count > N_LIMIT)
            return N_LIMIT;
        return int'(count);
    endfunction

    function automatic void add_request(input in_item_t it);
        pending_requests.insert(pending_requests.size(), it);
    endfunction

    function automatic void predict_distances(input logic [3:0] src);
        logic [DIST_BITS:0]   dist_est [MAX_NODES];
        logic [MAX_NODES-1:0] settled;
        logic [DIST_BITS:0]   best_d;
        logic [DIST_BITS:0]   sum;
        logic [WEIGHT_BITS-1:0] w;
        out_item_t res;
        int n;
        int best;
        int k;
        int step;
        n = nodes_in_use(node_count_model);
        for (k = 0; k < MAX_NODES; k++)
            dist_est[k] = DIST_INF;
        settled = '0;
        if (int'(src) < n)
            dist_est[src] = '0;
        for (step = 0; step < n; step++)
        begin
            best_d = DIST_INF;
            best = -1;
            for (k = 0; k < n; k++)
            begin
                if (!settled[k] && dist_est[k] < best_d)
                begin
                    best_d = dist_est[k];
                    best = k;
                end
            end
            // nothing reachable left, remaining nodes stay unreached
            if (best < 0)
                break;
            settled[best] = 1'b1;
            for (k = 0; k < n; k++)
            begin
                w = weight_model[best * MAX_NODES + k];
                if (w != 0 && !settled[k])
                begin
                    sum = best_d + w;
                    if (sum > DIST_MAX)
                        sum = DIST_MAX;
                    if (sum < dist_est[k])
                        dist_est[k] = sum;
                end
            end
        end
        for (k = 0; k < n; k++)
        begin
            res.node_index = k[3:0];
            res.reachable  = (dist_est[k] < DIST_INF);
            res.distance   = res.reachable ? dist_est[k][DIST_BITS-1:0] : '0;
            res.last       = (k == n - 1);
            expected_distances.insert(expected_distances.size(), res);
        end
    endfunction

    function automatic void track_request(input in_item_t req);
        int n;
        n = nodes_in_use(node_count_model);
        if (req.opcode == OP_COMPUTE)
            predict_distances(req.source_node);
        else if (int'(req.row_node) < n && int'(req.col_node) < n)
            weight_model[req.row_node * MAX_NODES + req.col_node] = req.edge_weight;
    endfunction

    function automatic void report_result(input string what, input out_item_t got,
                                          input out_item_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: got node %0d dist %0d reach %0b last %0b,",
                     what, got.node_index, got.distance, got.reachable, got.last,
                     " expected node %0d dist %0d reach %0b last %0b",
                     want.node_index, want.distance, want.reachable, want.last);
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t want;
        if (expected_distances.size() == 0)
        begin
            report_result("unexpected result", got, '0);
        end
        else
        begin
            want = expected_distances.pop_front();
            if (got.node_index !== want.node_index || got.distance !== want.distance ||
                got.reachable !== want.reachable || got.last !== want.last)
                report_result("result mismatch", got, want);
        end
    endfunction

    function automatic bit roll_idle();
        // one stretch of transactions runs with no idling on either side
        if (accepted_items >= 130 && accepted_items < 190)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic in_item_t random_fill();
        logic [$bits(in_item_t)-1:0] raw;
        raw = $bits(in_item_t)'($urandom);
        return in_item_t'(raw);
    endfunction

    function automatic in_item_t weight_write(input int row, input int col, input int w);
        in_item_t it;
        it = random_fill();
        it.opcode      = OP_WRITE;
        it.row_node    = row[3:0];
        it.col_node    = col[3:0];
        it.edge_weight = w[7:0];
        return it;
    endfunction

    function automatic in_item_t distance_query(input int src);
        in_item_t it;
        it = random_fill();
        it.opcode      = OP_COMPUTE;
        it.source_node = src[3:0];
        return it;
    endfunction

    function automatic in_item_t random_item(input int n);
        int row;
        int col;
        int w;
        if ($urandom_range(99) < 30)
            return distance_query(($urandom_range(99) < 85) ? $urandom_range(n - 1)
                                                            : $urandom_range(15));
        row = ($urandom_range(99) < 90) ? $urandom_range(n - 1) : $urandom_range(15);
        col = ($urandom_range(99) < 90) ? $urandom_range(n - 1) : $urandom_range(15);
        case ($urandom_range(3))
            0: w = 0;
            1: w = 255;
            2: w = $urandom_range(15, 1);
            default: w = $urandom_range(255);
        endcase
        return weight_write(row, col, w);
    endfunction

    // driver: offers queued requests, model updated on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin : drive
            bit slot_free;
            slot_free = !req_valid;
            if (req_valid && req_ready)
            begin
                track_request(req_data);
                accepted_items <= accepted_items + 1;
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (pending_requests.size() > 0 && !roll_idle())
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_requests.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off so the block backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_items >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each accepted result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                check_result(rsp_data);
            rsp_ready <= (hold_left == 0) && !roll_idle();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit all_settled();
        return pending_requests.size() == 0 && !req_valid && expected_distances.size() == 0;
    endfunction

    task automatic drain();
        while (!all_settled())
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        // a trailing write may still be in flight with no result to show for it
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        node_count_model = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [CFG_BITS-1:0] count, input int items,
                                input bit pause_midway);
        int i;
        write_node_count(count);
        for (i = 0; i < items; i++)
        begin
            add_request(random_item(nodes_in_use(count)));
            // sender stops here until every outstanding result has come back
            if (pause_midway && i == items / 2)
                drain();
        end
        settle();
    endtask

    initial
    begin
        for (int i = 0; i < MAT_DEPTH; i++)
            weight_model[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset node count, empty matrix first, then a small graph with ties
        add_request(distance_query(0));
        add_request(weight_write(0, 1, 255));
        add_request(weight_write(1, 2, 1));
        add_request(weight_write(0, 2, 255));
        add_request(weight_write(0, 5, 255));
        add_request(weight_write(2, 3, 7));
        add_request(weight_write(3, 3, 5));
        add_request(weight_write(15, 0, 1));
        add_request(weight_write(0, 15, 255));
        add_request(distance_query(0));
        add_request(distance_query(15));
        add_request(weight_write(0, 2, 0));
        add_request(distance_query(0));
        add_request(distance_query(7));
        settle();

        // writes and sources outside the nodes in use
        write_node_count(CFG_BITS'(4));
        add_request(weight_write(3, 0, 9));
        add_request(weight_write(4, 0, 9));
        add_request(weight_write(0, 4, 9));
        add_request(weight_write(1, 3, 2));
        add_request(distance_query(3));
        add_request(distance_query(4));
        add_request(distance_query(15));
        settle();

        // zero node count acts as a single node
        write_node_count(CFG_BITS'(0));
        add_request(distance_query(0));
        add_request(distance_query(1));
        settle();

        random_phase(CFG_BITS'(16), 70, 1'b0);
        random_phase(CFG_BITS'(31), 40, 1'b0);
        random_phase(CFG_BITS'(2), 30, 1'b0);
        random_phase(CFG_BITS'(1), 20, 1'b0);
        random_phase(CFG_BITS'($urandom_range(15, 3)), 50, 1'b0);
        random_phase(CFG_BITS'($urandom_range(31, 17)), 30, 1'b0);
        random_phase(CFG_BITS'(16), 70, 1'b1);

        if (mismatch_count == 0 && expected_distances.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
